>>> src/assert_macros.svh
// Assertion helpers for the glyph writer.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPGW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPGW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/spgw_pkg.sv
// ----------------------------------------------------------------------------
// spgw_pkg
// Shared constants and types for the split panel glyph writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spgw_pkg;

	// Glyph store geometry
	localparam int GLYPH_COUNT  = 256;
	localparam int GLYPH_BYTES  = 32;
	localparam int GLYPH_COLS   = 16;
	localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_BYTES;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);

	// Panel geometry
	localparam int SPLIT_COL    = 64;
	localparam int STRADDLE_LOW = 48;

	// Field widths
	localparam int GLYPH_W  = 8;
	localparam int OFFSET_W = 5;
	localparam int BYTE_W   = 8;
	localparam int COL_W    = 7;
	localparam int PAGE_W   = 3;

	// Panel command bytes
	localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'hB8;
	localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h40;

	// Request opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// One bus byte as issued by the sequencer
	typedef struct packed {
		logic              valid;
		logic              chip;
		logic              is_data;
		logic              zero;
		logic              last;
		logic [BYTE_W-1:0] cmd_byte;
	} tok_t;

endpackage

`default_nettype wire

>>> src/spgw_in_if.sv
// ----------------------------------------------------------------------------
// spgw_in_if
// Request channel: glyph load and draw requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spgw_in_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [spgw_pkg::GLYPH_W-1:0]   glyph_index;
	logic [spgw_pkg::OFFSET_W-1:0]  byte_offset;
	logic [spgw_pkg::BYTE_W-1:0]    glyph_byte;
	logic [spgw_pkg::COL_W-1:0]     column;
	logic [spgw_pkg::PAGE_W-1:0]    page;

	modport source (
		output valid, op, glyph_index, byte_offset, glyph_byte, column, page,
		input  ready
	);
	modport sink (
		input  valid, op, glyph_index, byte_offset, glyph_byte, column, page,
		output ready
	);
endinterface

`default_nettype wire

>>> src/spgw_out_if.sv
// ----------------------------------------------------------------------------
// spgw_out_if
// Panel bus channel: one command or data byte per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spgw_out_if;
	logic                         valid;
	logic                         ready;
	logic                         chip_select;
	logic                         is_data;
	logic [spgw_pkg::BYTE_W-1:0]  bus_byte;
	logic                         last_of_run;

	modport source (
		output valid, chip_select, is_data, bus_byte, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, chip_select, is_data, bus_byte, last_of_run,
		output ready
	);
endinterface

`default_nettype wire

>>> src/spgw_glyph_ram.sv
// ----------------------------------------------------------------------------
// spgw_glyph_ram
// Single-port-write, single-port-read glyph store with registered read data
// that holds while no read is enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spgw_glyph_ram #(
	parameter int DEPTH  = 8192,
	parameter int DATA_W = 8
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [DATA_W-1:0]         wdata,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [DATA_W-1:0]         rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/spgw_seq.sv
// ----------------------------------------------------------------------------
// spgw_seq
// Draw sequencer: walks four segments, each a page command, a column command
// and data bytes, with one shared down counter and issues one bus byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spgw_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           draw_fire,
	input  wire logic [spgw_pkg::GLYPH_W-1:0]   glyph_index,
	input  wire logic                           glyph_ok,
	input  wire logic [spgw_pkg::COL_W-1:0]     column,
	input  wire logic [spgw_pkg::PAGE_W-1:0]    page,
	input  wire logic                           advance,
	output logic                                idle,
	output spgw_pkg::tok_t                      tok,
	output logic                                rd_en,
	output logic [spgw_pkg::ADDR_W-1:0]         rd_addr
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PAGE   = 4'b0010,
		ST_COLUMN = 4'b0100,
		ST_DATA   = 4'b1000
	} state_t;

	localparam logic [4:0]                   N_FULL = 5'(spgw_pkg::GLYPH_COLS);
	localparam logic [spgw_pkg::COL_W-1:0]   C_LOW  = spgw_pkg::COL_W'(spgw_pkg::STRADDLE_LOW);
	localparam logic [spgw_pkg::COL_W-1:0]   C_SPL  = spgw_pkg::COL_W'(spgw_pkg::SPLIT_COL);

	state_t                         state_q, state_d;
	logic [1:0]                     seg_q, seg_d;
	logic [4:0]                     cnt_q, cnt_d;
	logic [4:0]                     pos_q, pos_d;
	logic [spgw_pkg::PAGE_W-1:0]    page_q;
	logic [spgw_pkg::GLYPH_W-1:0]   glyph_q;
	logic                           gok_q;
	logic [5:0]                     a_col_q, b_col_q, a_col_d, b_col_d;
	logic [4:0]                     a_n_q, b_n_q, a_n_d, b_n_d;

	logic                           chip;
	logic                           last_seg;
	logic [spgw_pkg::PAGE_W-1:0]    pg;
	logic [5:0]                     start;
	logic [4:0]                     n;
	logic                           cnt_one;
	logic [4:0]                     cnt_dec;
	logic [12:0]                    addr_full;

	// Split of the glyph at the controller boundary
	always_comb begin
		a_col_d = '0;
		b_col_d = '0;
		a_n_d   = '0;
		b_n_d   = '0;
		priority if (column <= C_LOW) begin
			a_col_d = column[5:0];
			a_n_d   = N_FULL;
		end else if (column >= C_SPL) begin
			b_col_d = column[5:0];
			b_n_d   = N_FULL;
		end else begin
			a_col_d = column[5:0];
			a_n_d   = 5'(C_SPL - column);
			b_n_d   = 5'(column - C_LOW);
		end
	end

	// Segment decode
	assign chip     = seg_q[0];
	assign last_seg = (seg_q == 2'd3);
	assign pg       = page_q + {2'b00, seg_q[1]};
	assign start    = chip ? b_col_q : a_col_q;
	assign n        = chip ? b_n_q : a_n_q;

	// Shared down counter and its end compare
	assign cnt_dec  = cnt_q - 5'd1;
	assign cnt_one  = (cnt_q == 5'd1);

	assign idle      = (state_q == ST_IDLE);
	assign addr_full = {glyph_q, pos_q};
	assign rd_addr   = addr_full[spgw_pkg::ADDR_W-1:0];
	assign rd_en     = advance && (state_q == ST_DATA);

	// Byte issued in the current step
	always_comb begin
		tok          = '0;
		tok.valid    = !idle;
		tok.chip     = chip;
		unique case (state_q)
			ST_PAGE: begin
				tok.cmd_byte = spgw_pkg::CMD_PAGE | {5'b0, pg};
			end
			ST_COLUMN: begin
				tok.cmd_byte = spgw_pkg::CMD_COLUMN | {2'b0, start};
				tok.last     = last_seg && (n == 5'd0);
			end
			ST_DATA: begin
				tok.is_data  = 1'b1;
				tok.zero     = !gok_q;
				tok.last     = last_seg && cnt_one;
			end
			default: begin
				tok.valid    = 1'b0;
			end
		endcase
	end

	// Step sequencing
	always_comb begin
		state_d = state_q;
		seg_d   = seg_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (draw_fire) begin
					state_d = ST_PAGE;
					seg_d   = 2'd0;
					pos_d   = 5'd0;
				end
			end
			ST_PAGE: begin
				if (advance) begin
					state_d = ST_COLUMN;
				end
			end
			ST_COLUMN: begin
				if (advance) begin
					if (n == 5'd0) begin
						state_d = last_seg ? ST_IDLE : ST_PAGE;
						seg_d   = seg_q + 2'd1;
					end else begin
						state_d = ST_DATA;
						cnt_d   = n;
					end
				end
			end
			ST_DATA: begin
				if (advance) begin
					pos_d = pos_q + 5'd1;
					cnt_d = cnt_dec;
					if (cnt_one) begin
						state_d = last_seg ? ST_IDLE : ST_PAGE;
						seg_d   = seg_q + 2'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
		end
	end

	// Draw parameters, captured on accept
	always_ff @(posedge clk) begin
		if (draw_fire) begin
			page_q  <= page;
			glyph_q <= glyph_index;
			gok_q   <= glyph_ok;
			a_col_q <= a_col_d;
			b_col_q <= b_col_d;
			a_n_q   <= a_n_d;
			b_n_q   <= b_n_d;
		end
	end

endmodule

`default_nettype wire

>>> src/split_panel_glyph_writer.sv
// ----------------------------------------------------------------------------
// split_panel_glyph_writer
// Glyph store plus draw sequencer that emits the command and data bytes for a
// 16x16 glyph on a panel split over two 64-column controllers.
// ----------------------------------------------------------------------------
// Load request: written into the store at the accept edge.
// Draw request: 40 bus bytes, one per cycle while the sink takes them; the
// first byte passes the sequencer state register and then the output stage.
// The sequencer steps once per byte; the next request is taken only once the
// sequencer is back in idle, which sink stalls during a draw can delay.
// Reset clears the sequencer and output stage; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module split_panel_glyph_writer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	spgw_in_if.sink    cmd,
	spgw_out_if.source panel
);

	logic                               idle;
	logic                               fire;
	logic                               glyph_ok;
	logic                               draw_fire;
	logic                               load_we;
	logic                               advance;
	spgw_pkg::tok_t                     tok;
	logic                               rd_en;
	logic [spgw_pkg::ADDR_W-1:0]        rd_addr;
	logic [spgw_pkg::BYTE_W-1:0]        rd_data;
	logic [12:0]                        wr_full;
	spgw_pkg::tok_t                     tok_s1;
	logic                               vld_s1;

	// Request decode
	assign cmd.ready = idle;
	assign fire      = cmd.valid && cmd.ready;
	assign glyph_ok  = ({1'b0, cmd.glyph_index} < 9'(spgw_pkg::GLYPH_COUNT));
	assign draw_fire = fire && (cmd.op == spgw_pkg::OP_DRAW);
	assign load_we   = fire && (cmd.op == spgw_pkg::OP_LOAD) && glyph_ok;
	assign wr_full   = {cmd.glyph_index, cmd.byte_offset};

	spgw_glyph_ram #(
		.DEPTH  (spgw_pkg::STORE_DEPTH),
		.DATA_W (spgw_pkg::BYTE_W)
	) u_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (wr_full[spgw_pkg::ADDR_W-1:0]),
		.wdata (cmd.glyph_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	spgw_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.draw_fire   (draw_fire),
		.glyph_index (cmd.glyph_index),
		.glyph_ok    (glyph_ok),
		.column      (cmd.column),
		.page        (cmd.page),
		.advance     (advance),
		.idle        (idle),
		.tok         (tok),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr)
	);

	// Output stage: the sequencer steps when this stage is free or drains
	assign advance = tok.valid && (!vld_s1 || panel.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || panel.ready) begin
			vld_s1 <= tok.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_s1 <= tok;
		end
	end

	// Data bytes come from the store read register, commands from the stage
	assign panel.valid       = vld_s1;
	assign panel.chip_select = tok_s1.chip;
	assign panel.is_data     = tok_s1.is_data;
	assign panel.last_of_run = tok_s1.last;
	assign panel.bus_byte    = !tok_s1.is_data ? tok_s1.cmd_byte
	                         : (tok_s1.zero ? '0 : rd_data);

	// Checks
	`SPGW_ASSERT_IMP(a_busy_not_ready, tok.valid, !cmd.ready, "ready while drawing")
	`SPGW_ASSERT_NXT(a_draw_starts_cmd, draw_fire, tok.valid && !tok.is_data, "draw did not start with a command")
	`SPGW_ASSERT_IMP(a_last_on_right, panel.valid && panel.last_of_run, panel.chip_select, "last byte not on right controller")

endmodule

`default_nettype wire

>>> tb/split_panel_glyph_writer_test.sv
// ----------------------------------------------------------------------------
// split_panel_glyph_writer_test
// Self-checking bench for the split panel glyph writer. Glyphs are loaded
// byte by byte, then drawn at columns left of, across and right of the panel
// split, on every page. A shadow glyph store predicts each draw's 40 bus
// bytes, and every byte taken from the panel channel is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module split_panel_glyph_writer_test;

	import spgw_pkg::*;

	// One request as queued for the driver
	typedef struct {
		logic                op;
		logic [GLYPH_W-1:0]  glyph_index;
		logic [OFFSET_W-1:0] byte_offset;
		logic [BYTE_W-1:0]   glyph_byte;
		logic [COL_W-1:0]    column;
		logic [PAGE_W-1:0]   page;
		bit                  drain_first;	// hold until all bus bytes are back
	} glyph_req_t;

	// One bus byte as seen on the panel channel
	typedef struct packed {
		logic              chip_select;
		logic              is_data;
		logic [BYTE_W-1:0] bus_byte;
		logic              last_of_run;
	} panel_byte_t;

	localparam int RANDOM_ITEMS = 360;
	localparam int HOLD_AFTER   = 800;	// bus bytes seen before the long hold
	localparam int HOLD_CYCLES  = 600;
	localparam int END_CYCLES   = 100;

	logic clk = 1'b0;
	logic arst_n;

	spgw_in_if  req_bus ();
	spgw_out_if panel_bus ();

	split_panel_glyph_writer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (req_bus),
		.panel  (panel_bus)
	);

	// Stimulus bookkeeping
	glyph_req_t            requests_pending [$];
	logic [GLYPH_BYTES-1:0] written_mask [GLYPH_COUNT];
	bit                    glyph_listed [GLYPH_COUNT];
	logic [GLYPH_W-1:0]    drawable_glyphs [$];
	int unsigned           items_queued;

	// Prediction and checking
	logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
	panel_byte_t       panel_bytes_due [$];
	int unsigned       mismatch_count;
	int unsigned       results_seen;

	// Idle pattern state, one set per side
	bit          drv_calm, snk_calm;
	int unsigned drv_calm_left, snk_calm_left;
	int unsigned send_gap, sink_gap, hold_left;
	bit          long_hold_done;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reset and known input levels from time zero
	initial begin
		arst_n               = 1'b0;
		req_bus.valid        = 1'b0;
		req_bus.op           = OP_LOAD;
		req_bus.glyph_index  = '0;
		req_bus.byte_offset  = '0;
		req_bus.glyph_byte   = '0;
		req_bus.column       = '0;
		req_bus.page         = '0;
		panel_bus.ready      = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic push_bus_byte(input logic chip, input logic data, input logic [BYTE_W-1:0] b);
		panel_byte_t pb;
		pb.chip_select = chip;
		pb.is_data     = data;
		pb.bus_byte    = b;
		pb.last_of_run = 1'b0;
		panel_bytes_due.push_back(pb);
	endtask

	// Shadow of the block: loads update the store, draws expand to bus bytes
	task automatic predict_panel_bytes(input glyph_req_t rq);
		int unsigned       left_col, right_col, left_n, right_n, start, n, pos;
		logic              chip;
		logic [PAGE_W-1:0] pg;
		if (rq.op == OP_LOAD) begin
			shadow_store[{rq.glyph_index, rq.byte_offset}] = rq.glyph_byte;
		end else begin
			left_col  = 0;
			right_col = 0;
			// split rule at the controller boundary
			if (rq.column <= STRADDLE_LOW) begin
				left_col = rq.column;
				left_n   = GLYPH_COLS;
				right_n  = 0;
			end else if (rq.column >= SPLIT_COL) begin
				right_col = rq.column - SPLIT_COL;
				left_n    = 0;
				right_n   = GLYPH_COLS;
			end else begin
				left_col = rq.column;
				left_n   = SPLIT_COL - rq.column;
				right_n  = rq.column - STRADDLE_LOW;
			end
			// left top, right top, left bottom, right bottom
			pos = 0;
			for (int seg = 0; seg < 4; seg++) begin
				chip  = seg[0];
				pg    = rq.page + PAGE_W'(seg >> 1);	// page 7 wraps to 0
				start = chip ? right_col : left_col;
				n     = chip ? right_n : left_n;
				push_bus_byte(chip, 1'b0, CMD_PAGE | BYTE_W'(pg));
				push_bus_byte(chip, 1'b0, CMD_COLUMN | BYTE_W'(start[5:0]));
				for (int k = 0; k < n; k++) begin
					push_bus_byte(chip, 1'b1, shadow_store[{rq.glyph_index, OFFSET_W'(pos)}]);
					pos++;
				end
			end
			panel_bytes_due[$].last_of_run = 1'b1;
		end
	endtask

	// Stimulus builders
	task automatic queue_load(input logic [GLYPH_W-1:0] g, input logic [OFFSET_W-1:0] off,
			input logic [BYTE_W-1:0] val);
		glyph_req_t rq;
		rq.op          = OP_LOAD;
		rq.glyph_index = g;
		rq.byte_offset = off;
		rq.glyph_byte  = val;
		rq.column      = COL_W'($urandom);
		rq.page        = PAGE_W'($urandom);
		rq.drain_first = 1'b0;
		requests_pending.push_back(rq);
		items_queued++;
		written_mask[g][off] = 1'b1;
		// a glyph may be drawn only once all its bytes hold data
		if (&written_mask[g] && !glyph_listed[g]) begin
			glyph_listed[g] = 1'b1;
			drawable_glyphs.push_back(g);
		end
	endtask

	task automatic queue_draw(input logic [GLYPH_W-1:0] g, input logic [COL_W-1:0] col,
			input logic [PAGE_W-1:0] pg, input bit drain);
		glyph_req_t rq;
		rq.op          = OP_DRAW;
		rq.glyph_index = g;
		rq.byte_offset = OFFSET_W'($urandom);
		rq.glyph_byte  = BYTE_W'($urandom);
		rq.column      = col;
		rq.page        = pg;
		rq.drain_first = drain;
		requests_pending.push_back(rq);
		items_queued++;
	endtask

	// Whole glyph in shuffled byte order
	task automatic queue_whole_glyph(input logic [GLYPH_W-1:0] g);
		int unsigned order [GLYPH_BYTES];
		int unsigned j, t;
		for (int i = 0; i < GLYPH_BYTES; i++)
			order[i] = i;
		for (int i = GLYPH_BYTES - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < GLYPH_BYTES; i++)
			queue_load(g, OFFSET_W'(order[i]), BYTE_W'($urandom));
	endtask

	// Request driver
	always @(posedge clk) begin
		bit offering;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			send_gap = 0;
		end else begin
			offering = req_bus.valid;
			if (req_bus.valid && req_bus.ready) begin
				predict_panel_bytes(requests_pending.pop_front());
				offering = 1'b0;
				send_gap = pick_gap(drv_calm);
			end
			if (drv_calm_left == 0) begin
				drv_calm      = ($urandom_range(0, 3) == 0);
				drv_calm_left = $urandom_range(30, 150);
			end else begin
				drv_calm_left--;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (requests_pending.size() != 0 &&
						!(requests_pending[0].drain_first && panel_bytes_due.size() != 0)) begin
					offering = 1'b1;
					req_bus.op          <= requests_pending[0].op;
					req_bus.glyph_index <= requests_pending[0].glyph_index;
					req_bus.byte_offset <= requests_pending[0].byte_offset;
					req_bus.glyph_byte  <= requests_pending[0].glyph_byte;
					req_bus.column      <= requests_pending[0].column;
					req_bus.page        <= requests_pending[0].page;
				end
			end
			req_bus.valid <= offering;
		end
	end

	// Panel side ready, with one long hold to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			panel_bus.ready <= 1'b0;
		end else begin
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				hold_left      = HOLD_CYCLES;
			end
			if (snk_calm_left == 0) begin
				snk_calm      = ($urandom_range(0, 3) == 0);
				snk_calm_left = $urandom_range(30, 150);
			end else begin
				snk_calm_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				panel_bus.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				panel_bus.ready <= 1'b0;
			end else begin
				sink_gap = pick_gap(snk_calm);
				panel_bus.ready <= (sink_gap == 0);
			end
		end
	end

	// Bus byte checker
	always @(posedge clk) begin
		panel_byte_t want;
		if (arst_n && panel_bus.valid && panel_bus.ready) begin
			results_seen++;
			if (panel_bytes_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected bus byte cs=%0b dc=%0b byte=%02h last=%0b",
					panel_bus.chip_select, panel_bus.is_data, panel_bus.bus_byte,
					panel_bus.last_of_run));
			end else begin
				want = panel_bytes_due.pop_front();
				if (panel_bus.chip_select !== want.chip_select)
					flag_mismatch($sformatf("byte %0d chip_select %0b, want %0b", results_seen,
						panel_bus.chip_select, want.chip_select));
				if (panel_bus.is_data !== want.is_data)
					flag_mismatch($sformatf("byte %0d is_data %0b, want %0b", results_seen,
						panel_bus.is_data, want.is_data));
				if (panel_bus.bus_byte !== want.bus_byte)
					flag_mismatch($sformatf("byte %0d bus_byte %02h, want %02h", results_seen,
						panel_bus.bus_byte, want.bus_byte));
				if (panel_bus.last_of_run !== want.last_of_run)
					flag_mismatch($sformatf("byte %0d last_of_run %0b, want %0b", results_seen,
						panel_bus.last_of_run, want.last_of_run));
			end
		end
	end

	// Stimulus plan and end of run
	initial begin
		int unsigned r;
		logic [COL_W-1:0] col;
		for (int g = 0; g < GLYPH_COUNT; g++) begin
			written_mask[g] = '0;
			glyph_listed[g] = 1'b0;
		end

		// directed: both end glyphs, extreme data, every split case and page wrap
		queue_whole_glyph(0);
		queue_whole_glyph(GLYPH_COUNT - 1);
		queue_load(0, 0, 8'h00);
		queue_load(GLYPH_COUNT - 1, GLYPH_BYTES - 1, 8'hFF);
		queue_draw(0, 0, 0, 1'b0);
		queue_draw(GLYPH_COUNT - 1, 48, 1, 1'b0);
		queue_draw(0, 49, 2, 1'b0);
		queue_draw(GLYPH_COUNT - 1, 63, 3, 1'b0);
		queue_draw(0, 56, 4, 1'b0);
		queue_draw(GLYPH_COUNT - 1, 64, 6, 1'b0);
		queue_draw(0, 111, 7, 1'b0);
		queue_draw(GLYPH_COUNT - 1, 112, 5, 1'b0);
		queue_draw(0, 127, 0, 1'b0);
		queue_draw(GLYPH_COUNT - 1, 16, 7, 1'b0);
		queue_draw(0, 96, 6, 1'b0);

		// random: whole glyph loads, draws of loaded glyphs, stray byte loads
		queue_draw(drawable_glyphs[0], 32, 3, 1'b1);
		while (items_queued < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < (drawable_glyphs.size() < 6 ? 10 : 3)) begin
				queue_whole_glyph(GLYPH_W'($urandom));
			end else if (r < 62) begin
				col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(112, 127))
					: COL_W'($urandom_range(0, 111));
				queue_draw(drawable_glyphs[$urandom_range(0, drawable_glyphs.size() - 1)],
					col, PAGE_W'($urandom), ($urandom_range(0, 39) == 0));
			end else begin
				queue_load(GLYPH_W'($urandom), OFFSET_W'($urandom), BYTE_W'($urandom));
			end
		end

		// drain
		while (requests_pending.size() != 0 || req_bus.valid)
			@(posedge clk);
		while (panel_bytes_due.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
